[rtl/swam_pkg.sv]
package swam_pkg;

    localparam int MAX_SENSORS = 16;
    localparam int WINDOW_LOG2 = 3;
    localparam int WINDOW      = 1 << WINDOW_LOG2;

    localparam int ENTRY_W = (MAX_SENSORS > 1) ? $clog2(MAX_SENSORS) : 1;
    localparam int COUNT_W = $clog2(MAX_SENSORS + 1);
    localparam int SLOT_W  = (WINDOW_LOG2 > 0) ? WINDOW_LOG2 : 1;
    localparam int FILL_W  = $clog2(WINDOW + 1);
    localparam int TEMP_W  = 16;
    localparam int SUM_W   = TEMP_W + WINDOW_LOG2;
    localparam int ID_W    = 16;
    localparam int ROOM_W  = 16;
    localparam int TIME_W  = 32;

    localparam logic [1:0] CMD_ADD   = 2'd0;
    localparam logic [1:0] CMD_READ  = 2'd1;
    localparam logic [1:0] CMD_QUERY = 2'd2;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_UNKNOWN = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;

    localparam logic [1:0] ALARM_NONE = 2'd0;
    localparam logic [1:0] ALARM_HIGH = 2'd1;
    localparam logic [1:0] ALARM_LOW  = 2'd2;

    localparam logic CFG_MAX_TEMP = 1'b0;
    localparam logic CFG_MIN_TEMP = 1'b1;

    localparam logic signed [TEMP_W-1:0] MAX_TEMP_RESET = 16'sd6400;
    localparam logic signed [TEMP_W-1:0] MIN_TEMP_RESET = 16'sd2560;

    typedef enum logic {
        S_IDLE,
        S_BUSY
    } t_state;

    typedef struct packed {
        logic [1:0]               command;
        logic [ID_W-1:0]          sensor_number;
        logic [ROOM_W-1:0]        room_number;
        logic signed [TEMP_W-1:0] temperature;
        logic [TIME_W-1:0]        timestamp;
    } t_in_item;

    typedef struct packed {
        logic [1:0]               status;
        logic [ROOM_W-1:0]        owner_room;
        logic signed [TEMP_W-1:0] average;
        logic                     average_valid;
        logic [1:0]               alarm;
        logic [TIME_W-1:0]        last_time;
        logic [COUNT_W-1:0]       sensor_total;
    } t_out_item;

    typedef struct packed {
        logic [ROOM_W-1:0]        room;
        logic signed [SUM_W-1:0]  sum;
        logic signed [TEMP_W-1:0] average;
        logic [TIME_W-1:0]        last_time;
    } t_entry;

endpackage

[rtl/sensor_window_average_monitor_top.sv]
// Per-sensor moving-average temperature monitor.
// Input channel (i_in_valid, o_in_ready, i_in_data) carries add, reading and
// query items; every item produces exactly one result on the output channel
// (o_out_valid, i_out_ready, o_out_data).
// The configuration channel (i_cfg_valid, o_cfg_ready, i_cfg_index, i_cfg_data)
// sets the high and low alarm thresholds; it is always ready and should only
// be used while no item is in flight.
// In the cycle of an input transfer the id is matched against the table in
// flip-flops and the sensor's entry and oldest sample are read from their
// memories; in the following cycle the entry is updated, written back and the
// result is loaded into the output register, so a result passes the input
// capture registers and then the output register. No item is taken while
// the entry is being updated and written back; o_in_ready is low then.
// The next item is taken while the current result is being transferred; if
// the receiver stalls, the result is held and o_in_ready stays low.
// After reset the table is empty and the thresholds return to their defaults;
// the memories need no clearing pass.
module sensor_window_average_monitor_top
    import swam_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  t_in_item                 i_in_data,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output t_out_item                o_out_data,
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic                     i_cfg_index,
    input  logic signed [TEMP_W-1:0] i_cfg_data
);

    t_state r_state, n_state;

    logic [ID_W-1:0]   r_id_table [MAX_SENSORS];
    logic [SLOT_W-1:0] r_slot     [MAX_SENSORS];
    logic [FILL_W-1:0] r_fill     [MAX_SENSORS];
    logic [COUNT_W-1:0] r_used;

    logic signed [TEMP_W-1:0] r_max_temp;
    logic signed [TEMP_W-1:0] r_min_temp;

    t_entry                   entry_mem  [MAX_SENSORS];
    logic signed [TEMP_W-1:0] sample_mem [MAX_SENSORS * WINDOW];
    t_entry                   r_entry_q;
    logic signed [TEMP_W-1:0] r_sample_q;

    t_in_item           r_item;
    logic               r_hit;
    logic [ENTRY_W-1:0] r_idx;
    logic [SLOT_W-1:0]  r_slot_q;
    logic [FILL_W-1:0]  r_fill_q;

    t_out_item r_out;
    logic      r_out_valid;

    logic               in_xfer;
    logic               busy;
    logic               lk_hit;
    logic [ENTRY_W-1:0] lk_idx;

    logic                     wr_entry;
    logic [ENTRY_W-1:0]       wr_entry_addr;
    t_entry                   wr_entry_data;
    logic                     wr_sample;
    logic                     wr_add;
    logic                     wr_read;
    t_out_item                n_out;
    logic                     full_q;
    logic [FILL_W-1:0]        fill_next;
    logic signed [SUM_W-1:0]  old_ext;
    logic signed [SUM_W-1:0]  new_ext;
    logic signed [SUM_W-1:0]  new_sum;
    logic signed [SUM_W-1:0]  sum_shr;
    logic signed [TEMP_W-1:0] new_avg;
    logic signed [TEMP_W-1:0] rep_avg;
    logic                     rep_valid;

    assign in_xfer     = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    n_state = S_BUSY;
                end
            end
            S_BUSY: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        busy       = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = !r_out_valid || i_out_ready;
            end
            S_BUSY: begin
                busy = 1'b1;
            end
            default: begin
                busy = 1'b0;
            end
        endcase
    end

    always_comb begin
        lk_hit = 1'b0;
        lk_idx = '0;
        for (int i = MAX_SENSORS - 1; i >= 0; i--) begin
            if ((COUNT_W'(i) < r_used) && (r_id_table[i] == i_in_data.sensor_number)) begin
                lk_hit = 1'b1;
                lk_idx = ENTRY_W'(i);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_item     <= i_in_data;
            r_hit      <= lk_hit;
            r_idx      <= lk_idx;
            r_slot_q   <= r_slot[lk_idx];
            r_fill_q   <= r_fill[lk_idx];
            r_entry_q  <= entry_mem[lk_idx];
            r_sample_q <= sample_mem[{lk_idx, r_slot[lk_idx]}];
        end
    end

    always_comb begin
        full_q    = r_fill_q >= FILL_W'(WINDOW);
        fill_next = full_q ? r_fill_q : r_fill_q + 1'b1;
        old_ext   = full_q ? {{(SUM_W - TEMP_W){r_sample_q[TEMP_W-1]}}, r_sample_q} : '0;
        new_ext   = {{(SUM_W - TEMP_W){r_item.temperature[TEMP_W-1]}}, r_item.temperature};
        new_sum   = r_entry_q.sum - old_ext + new_ext;
        sum_shr   = new_sum >>> WINDOW_LOG2;
        new_avg   = (fill_next == FILL_W'(WINDOW)) ? sum_shr[TEMP_W-1:0] : '0;

        wr_entry      = 1'b0;
        wr_entry_addr = r_idx;
        wr_entry_data = r_entry_q;
        wr_sample     = 1'b0;
        wr_add        = 1'b0;
        wr_read       = 1'b0;
        rep_avg       = r_entry_q.average;
        rep_valid     = full_q;

        n_out              = '0;
        n_out.status       = ST_OK;
        n_out.alarm        = ALARM_NONE;
        n_out.sensor_total = r_used;

        unique case (r_item.command)
            CMD_ADD: begin
                if (r_used >= COUNT_W'(MAX_SENSORS)) begin
                    n_out.status = ST_FULL;
                end else begin
                    wr_add                  = busy;
                    wr_entry                = busy;
                    wr_entry_addr           = r_used[ENTRY_W-1:0];
                    wr_entry_data           = '0;
                    wr_entry_data.room      = r_item.room_number;
                    n_out.owner_room        = r_item.room_number;
                    n_out.sensor_total      = r_used + 1'b1;
                end
            end
            CMD_READ, CMD_QUERY: begin
                if (!r_hit) begin
                    n_out.status = ST_UNKNOWN;
                end else begin
                    if (r_item.command == CMD_READ) begin
                        wr_read                 = busy;
                        wr_entry                = busy;
                        wr_sample               = busy;
                        wr_entry_data.sum       = new_sum;
                        wr_entry_data.average   = new_avg;
                        wr_entry_data.last_time = r_item.timestamp;
                        rep_avg                 = new_avg;
                        rep_valid               = fill_next >= FILL_W'(WINDOW);
                    end
                    n_out.owner_room    = r_entry_q.room;
                    n_out.average       = rep_avg;
                    n_out.average_valid = rep_valid;
                    n_out.last_time     = wr_entry_data.last_time;
                    if (rep_valid) begin
                        priority if (rep_avg > r_max_temp) begin
                            n_out.alarm = ALARM_HIGH;
                        end else if (rep_avg < r_min_temp) begin
                            n_out.alarm = ALARM_LOW;
                        end else begin
                            n_out.alarm = ALARM_NONE;
                        end
                    end
                end
            end
            default: begin
                n_out.status = ST_OK;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_entry) begin
            entry_mem[wr_entry_addr] <= wr_entry_data;
        end
        if (wr_sample) begin
            sample_mem[{r_idx, r_slot_q}] <= r_item.temperature;
        end
        if (wr_add) begin
            r_id_table[r_used[ENTRY_W-1:0]] <= r_item.sensor_number;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_used      <= '0;
            r_max_temp  <= MAX_TEMP_RESET;
            r_min_temp  <= MIN_TEMP_RESET;
            r_out_valid <= 1'b0;
            for (int i = 0; i < MAX_SENSORS; i++) begin
                r_slot[i] <= '0;
                r_fill[i] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    CFG_MAX_TEMP: r_max_temp <= i_cfg_data;
                    CFG_MIN_TEMP: r_min_temp <= i_cfg_data;
                    default:      r_max_temp <= r_max_temp;
                endcase
            end
            if (wr_add) begin
                r_used                     <= r_used + 1'b1;
                r_slot[r_used[ENTRY_W-1:0]] <= '0;
                r_fill[r_used[ENTRY_W-1:0]] <= '0;
            end
            if (wr_read) begin
                r_slot[r_idx] <= r_slot_q + 1'b1;
                r_fill[r_idx] <= fill_next;
            end
            if (busy) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (busy) begin
            r_out <= n_out;
        end
    end

endmodule
